>>> hdl/prr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_pkg
// Shared types, codes and helpers of the pressure response receiver.
// ----------------------------------------------------------------------------
package prr_pkg;

	localparam int CHANNELS    = 4;
	localparam int PAYLOAD_LEN = 8;
	localparam int CODE_W      = 10;
	localparam int PRESS_W     = 24;
	localparam int MISS_W      = 8;
	localparam int TAG_W       = 2;

	// Item kinds on the input stream
	typedef enum logic [1:0] {
		K_BEGIN   = 2'd0,
		K_BYTE    = 2'd1,
		K_END     = 2'd2,
		K_TIMEOUT = 2'd3
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_NOFRAME = 2'd1,
		ST_TIMEOUT = 2'd2,
		ST_LOST    = 2'd3
	} status_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ZERO_CODE  = 2'd0,
		REG_KPA_GAIN   = 2'd1,
		REG_ALPHA      = 2'd2,
		REG_LOST_LIMIT = 2'd3
	} cfg_reg_t;

	localparam logic [9:0]  ZERO_CODE_RST  = 10'd102;
	localparam logic [23:0] KPA_GAIN_RST   = 24'd65536;
	localparam logic [8:0]  ALPHA_RST      = 9'd154;
	localparam logic [7:0]  LOST_LIMIT_RST = 8'd10;
	localparam logic [8:0]  ALPHA_ONE      = 9'd256;

	typedef logic [CHANNELS-1:0][CODE_W-1:0] code_arr_t;

	// One memory row per joint
	typedef struct packed {
		logic [MISS_W-1:0]                miss;
		logic [CHANNELS-1:0][PRESS_W-1:0] press;
	} row_t;

	// Receive-side control strobes
	typedef struct packed {
		logic poll_start;
		logic take;
		logic clear;
	} rx_ctrl_t;

	typedef struct packed {
		logic                      valid;
		logic [TAG_W-1:0]          tag;
		logic signed [10:0]        diff;
		logic signed [PRESS_W-1:0] prev;
	} chan_in_t;

	typedef struct packed {
		logic                      valid;
		logic [TAG_W-1:0]          tag;
		logic signed [PRESS_W-1:0] value;
	} chan_out_t;

	function automatic logic signed [PRESS_W-1:0] sat24(input logic signed [39:0] v);
		if (v > 40'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -40'sd8388608) begin
			return 24'sh800000;
		end else begin
			return v[PRESS_W-1:0];
		end
	endfunction

endpackage

>>> hdl/prr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/prr_rx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_rx
// Reply frame parser: address search, payload capture, code check.
// ----------------------------------------------------------------------------
module prr_rx
	import prr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  rx_ctrl_t  ctrl,
	input  logic [7:0] byte_value,
	input  logic [2:0] cur_joint,
	output logic      frame_good,
	output code_arr_t good_codes
);

	logic [7:0]  prev_q;
	logic [3:0]  cnt_q;
	logic        fg_q;
	logic [7:0]  pl_q [PAYLOAD_LEN];
	code_arr_t   codes_q;
	code_arr_t   codes_n;
	logic        codes_ok;
	logic        addr_hit;
	logic        last_byte;
	logic [15:0] addr_want;

	assign addr_want = 16'hFFFF - {13'd0, cur_joint};
	assign addr_hit  = ({prev_q, byte_value} == addr_want);
	assign last_byte = (cnt_q == 4'(PAYLOAD_LEN));

	// Last byte comes straight from the input, not from the store
	always_comb begin
		logic [7:0] hi;
		logic [7:0] lo;
		codes_ok = 1'b1;
		for (int i = 0; i < CHANNELS; i++) begin
			hi = pl_q[2*i];
			lo = (i == CHANNELS - 1) ? byte_value : pl_q[2*i+1];
			codes_n[i] = {hi[1:0], lo};
			if (hi[7:2] != 6'd0) begin
				codes_ok = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 8'd0;
			cnt_q  <= 4'd0;
			fg_q   <= 1'b0;
		end else if (ctrl.poll_start || ctrl.clear) begin
			prev_q <= 8'd0;
			cnt_q  <= 4'd0;
			fg_q   <= 1'b0;
		end else if (ctrl.take) begin
			if (cnt_q == 4'd0) begin
				if (addr_hit) begin
					cnt_q  <= 4'd1;
					prev_q <= 8'd0;
				end else begin
					prev_q <= byte_value;
				end
			end else if (!last_byte) begin
				cnt_q <= cnt_q + 4'd1;
			end else begin
				fg_q   <= codes_ok;
				cnt_q  <= 4'd0;
				prev_q <= 8'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take && (cnt_q != 4'd0)) begin
			pl_q[3'(cnt_q - 4'd1)] <= byte_value;
		end
		if (ctrl.take && last_byte && codes_ok) begin
			codes_q <= codes_n;
		end
	end

	assign frame_good = fg_q;
	assign good_codes = codes_q;

endmodule

>>> hdl/prr_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_chan
// Four-stage channel pipeline: code to kPa Q8, then first-order low-pass.
// ----------------------------------------------------------------------------
module prr_chan
	import prr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [23:0] kpa_gain,
	input  logic [8:0]  alpha_c,
	input  chan_in_t    din,
	output chan_out_t   dout
);

	logic [3:0]             vld_q;
	logic [TAG_W-1:0]       tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [35:0]     prod_s1;
	logic signed [PRESS_W-1:0] prev_s1, prev_s2;
	logic signed [PRESS_W-1:0] p_s2;
	logic signed [33:0]     mnew_s3, mold_s3;
	logic signed [PRESS_W-1:0] f_s4;

	logic signed [35:0]     rnd1, sh1;
	logic signed [34:0]     sum2, sh2;
	logic [8:0]             alpha_n;

	assign alpha_n = ALPHA_ONE - alpha_c;
	assign rnd1    = prod_s1 + 36'sd128;
	assign sh1     = rnd1 >>> 8;
	assign sum2    = $signed({mold_s3[33], mold_s3}) + $signed({mnew_s3[33], mnew_s3})
		+ 35'sd128;
	assign sh2     = sum2 >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 4'd0;
		end else begin
			vld_q <= {vld_q[2:0], din.valid};
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: scale by gain
		prod_s1 <= din.diff * $signed({1'b0, kpa_gain});
		prev_s1 <= din.prev;
		tag_s1  <= din.tag;
		// stage 2: round to Q8, saturate
		p_s2    <= sat24({{4{sh1[35]}}, sh1});
		prev_s2 <= prev_s1;
		tag_s2  <= tag_s1;
		// stage 3: filter weights
		mnew_s3 <= $signed({1'b0, alpha_c}) * p_s2;
		mold_s3 <= $signed({1'b0, alpha_n}) * prev_s2;
		tag_s3  <= tag_s2;
		// stage 4: sum, round, saturate
		f_s4    <= sat24({{5{sh2[34]}}, sh2});
		tag_s4  <= tag_s3;
	end

	assign dout.valid = vld_q[3];
	assign dout.tag   = tag_s4;
	assign dout.value = f_s4;

endmodule

>>> hdl/pressure_response_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_response_receiver_core
// Receives pressure-board reply frames, converts the four channel codes of
// a good frame to filtered kPa per joint and keeps per-joint miss counts.
// ----------------------------------------------------------------------------
//  channel  | direction | fields
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | tuser: kind; tdata: joint, byte_value
//  m_*      | out       | tuser: status; tdata: joint_out, pressure_a..d,
//           |           |        miss_count
//  cfg_*    | in        | write-only: zero_code, kpa_gain, alpha, lost_limit
//
// Begin and byte words are accepted while idle and keep the core idle. An
// end or timeout word that leaves the filters alone steps through accept,
// row read and write-back; an end with a good frame also sends the four
// channels one a cycle through the four-stage channel pipeline between
// row read and write-back. The write-back stalls while the previous result
// still waits on m_tready. Reset clears control state and the row valid bits
// and loads the configuration defaults; a row never written reads as zero.
// ----------------------------------------------------------------------------
module pressure_response_receiver_core
	import prr_pkg::*;
#(
	parameter int MAX_JOINTS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // [2:0] joint, [10:3] byte_value, rest zero
	input  logic [1:0]   s_tuser,   // [1:0] kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // [2:0] joint_out, [26:3] pressure_a,
	                                // [50:27] pressure_b, [74:51] pressure_c,
	                                // [98:75] pressure_d, [106:99] miss_count
	output logic [1:0]   m_tuser,   // [1:0] status
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [23:0]  cfg_wdata
);

	localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_LOAD  = 5'b00010,
		S_CALC  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_WRITE = 5'b10000
	} state_t;

	// Configuration
	logic [9:0]  zero_code_q;
	logic [23:0] kpa_gain_q;
	logic [8:0]  alpha_q;
	logic [7:0]  lost_limit_q;
	logic [8:0]  alpha_c;

	// Control
	state_t          state_q;
	logic [2:0]      cur_joint_q;
	logic            timeout_q;
	logic            fg_q;
	logic [TAG_W-1:0] issue_q;
	logic [2:0]      got_q;
	logic [MAX_JOINTS-1:0] valid_q;
	status_t         status_q;
	row_t            row_q;

	// Output register
	logic            m_tvalid_q;
	logic [111:0]    out_data_q;
	status_t         out_status_q;

	logic            s_acc;
	kind_t           in_kind;
	logic [2:0]      in_joint;
	logic [7:0]      in_byte;
	logic            joint_ok;
	logic [JW-1:0]   jidx;
	logic            out_free;

	logic            ram_re, ram_we;
	logic [$bits(row_t)-1:0] ram_rdata;
	row_t            rd_row;
	logic [7:0]      miss_inc;

	rx_ctrl_t        rx_ctrl;
	logic            frame_good;
	code_arr_t       good_codes;
	chan_in_t        chan_in;
	chan_out_t       chan_out;

	assign in_kind  = kind_t'(s_tuser);
	assign in_joint = s_tdata[2:0];
	assign in_byte  = s_tdata[10:3];
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign joint_ok = (32'(in_joint) < MAX_JOINTS);
	assign jidx     = JW'({{JW{1'b0}}, cur_joint_q});
	assign out_free = !m_tvalid_q || m_tready;
	assign alpha_c  = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

	// Hold configuration; writes must arrive only while idle, which the core does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_code_q  <= ZERO_CODE_RST;
			kpa_gain_q   <= KPA_GAIN_RST;
			alpha_q      <= ALPHA_RST;
			lost_limit_q <= LOST_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_ZERO_CODE:  zero_code_q  <= cfg_wdata[9:0];
				REG_KPA_GAIN:   kpa_gain_q   <= cfg_wdata;
				REG_ALPHA:      alpha_q      <= cfg_wdata[8:0];
				REG_LOST_LIMIT: lost_limit_q <= cfg_wdata[7:0];
			endcase
		end
	end

	// Frame parser strobes
	always_comb begin
		rx_ctrl.poll_start = s_acc && (in_kind == K_BEGIN) && joint_ok;
		rx_ctrl.take       = s_acc && (in_kind == K_BYTE);
		rx_ctrl.clear      = s_acc && ((in_kind == K_END) || (in_kind == K_TIMEOUT));
	end

	prr_rx u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (rx_ctrl),
		.byte_value (in_byte),
		.cur_joint  (cur_joint_q),
		.frame_good (frame_good),
		.good_codes (good_codes)
	);

	// Per-joint row store: one read on accept, one write-back at the end.
	// Only one item is in flight, so the write always lands before the
	// next read of the same row.
	assign ram_re = rx_ctrl.clear;
	assign ram_we = (state_q == S_WRITE) && out_free;

	prr_ram #(
		.WIDTH ($bits(row_t)),
		.DEPTH (MAX_JOINTS)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (jidx),
		.wdata (row_q),
		.re    (ram_re),
		.raddr (jidx),
		.rdata (ram_rdata)
	);

	// Unwritten rows read as zero
	assign rd_row   = valid_q[jidx] ? row_t'(ram_rdata) : '0;
	assign miss_inc = (rd_row.miss == 8'hFF) ? rd_row.miss : rd_row.miss + 8'd1;

	// Feed one channel a cycle into the filter pipeline
	always_comb begin
		chan_in.valid = (state_q == S_CALC);
		chan_in.tag   = issue_q;
		chan_in.diff  = $signed({1'b0, good_codes[issue_q]}) - $signed({1'b0, zero_code_q});
		chan_in.prev  = row_q.press[issue_q];
	end

	prr_chan u_chan (
		.clk      (clk),
		.arst_n   (arst_n),
		.kpa_gain (kpa_gain_q),
		.alpha_c  (alpha_c),
		.din      (chan_in),
		.dout     (chan_out)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_joint_q <= 3'd0;
			timeout_q   <= 1'b0;
			fg_q        <= 1'b0;
			issue_q     <= '0;
			got_q       <= 3'd0;
			valid_q     <= '0;
			status_q    <= ST_NOFRAME;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (chan_out.valid) begin
				got_q <= got_q + 3'd1;
			end
			// Drop the result once taken, unless a new one replaces it now
			if (m_tvalid_q && m_tready && !ram_we) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (rx_ctrl.poll_start) begin
						cur_joint_q <= in_joint;
					end
					if (rx_ctrl.clear) begin
						timeout_q <= (in_kind == K_TIMEOUT);
						fg_q      <= frame_good;
						state_q   <= S_LOAD;
					end
				end
				S_LOAD: begin
					issue_q <= '0;
					got_q   <= 3'd0;
					if (timeout_q) begin
						status_q <= (miss_inc > lost_limit_q) ? ST_LOST : ST_TIMEOUT;
						state_q  <= S_WRITE;
					end else if (fg_q) begin
						status_q <= ST_UPDATED;
						state_q  <= S_CALC;
					end else begin
						status_q <= ST_NOFRAME;
						state_q  <= S_WRITE;
					end
				end
				S_CALC: begin
					issue_q <= issue_q + 1'b1;
					if (issue_q == TAG_W'(CHANNELS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (got_q == 3'(CHANNELS)) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					// Advance only once the output slot is free
					if (out_free) begin
						valid_q[jidx] <= 1'b1;
						m_tvalid_q    <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Row working copy and output payload
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			row_q.press <= rd_row.press;
			if (timeout_q) begin
				row_q.miss <= miss_inc;
			end else if (fg_q) begin
				row_q.miss <= 8'd0;
			end else begin
				row_q.miss <= rd_row.miss;
			end
		end
		if (chan_out.valid) begin
			row_q.press[chan_out.tag] <= chan_out.value;
		end
		if (ram_we) begin
			out_data_q   <= {5'd0, row_q.miss, row_q.press, cur_joint_q};
			out_status_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

`ifndef ASSERT_OFF
	a_updated_clears_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_UPDATED)) |-> (m_tdata[106:99] == 8'd0))
		else $error("updated result with nonzero miss count");

	a_lost_above_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_LOST)) |-> (m_tdata[106:99] > lost_limit_q))
		else $error("lost reported at or below limit");

	a_writeback_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> m_tvalid)
		else $error("row write-back without a result");

	a_chan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		chan_out.valid |-> ((state_q == S_CALC) || (state_q == S_DRAIN)))
		else $error("channel result outside filter phase");

	a_got_bound: assert property (@(posedge clk) disable iff (!arst_n)
		got_q <= 3'(CHANNELS))
		else $error("more channel results than channels");
`endif

endmodule
